// ===== rtl/mtst_pkg.sv =====
package mtst_pkg;

    // Default slot count
    localparam int MAX_SLOTS_DEF = 5;

    // Field widths
    localparam int SLOT_ID_W  = 4;
    localparam int COORD_W    = 32;
    localparam int TYPE_W     = 16;
    localparam int CODE_W     = 16;
    localparam int OFF_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Mapping datapath widths
    localparam int DIFF_W     = COORD_W + 1;          // raw - raw_min, signed
    localparam int SPAN_MAG_W = SIZE_W;               // |size - 1|
    localparam int PROD_W     = DIFF_W + SPAN_MAG_W;  // product / dividend magnitude
    localparam int VAL_W      = PROD_W + 1;           // signed quotient plus origin
    localparam int HI_W       = OFF_W + 3;            // signed window high edge
    localparam int CNT_W      = $clog2(PROD_W + 1);

    // Event types and codes
    localparam logic [TYPE_W-1:0] EVT_KEY    = 16'd1;
    localparam logic [TYPE_W-1:0] EVT_ABS    = 16'd3;
    localparam logic [CODE_W-1:0] CODE_X     = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_Y     = 16'h0001;
    localparam logic [CODE_W-1:0] CODE_SLOT  = 16'h002f;
    localparam logic [CODE_W-1:0] CODE_MT_X  = 16'h0035;
    localparam logic [CODE_W-1:0] CODE_MT_Y  = 16'h0036;
    localparam logic [CODE_W-1:0] CODE_TRACK = 16'h0039;
    localparam logic [CODE_W-1:0] CODE_TOUCH = 16'h014a;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_ENABLE,
        REG_RAW_MIN_X,
        REG_RAW_MAX_X,
        REG_RAW_MIN_Y,
        REG_RAW_MAX_Y
    } t_cfg_reg;

    // Report sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIX,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/multitouch_slot_tracker_unit.sv =====
// Multitouch slot tracker.
// Input channel (i_in_valid / o_in_ready) carries either a touch event
// (i_req_type = 0) or a report request (i_req_type = 1). Events update the
// slot table in the cycle they are accepted and produce no output; the block
// stays ready for the next transaction.
// A report walks the slots in ascending order and emits one transaction per
// active slot on the output channel (o_out_valid / i_out_ready), with o_last
// on the final one, or a single none_active transaction when no slot is on.
// Uncalibrated, a report skips the multiply and divide. Calibrated, each
// axis runs through one shared bit-serial unit: a shift-add multiply
// and a restoring divide plus setup and clamp.
// The input is not taken while a report is in progress. Results go through an
// output register: a stalled receiver holds the sequencer at the next result,
// and once the final result is registered new transactions are accepted.
// Reset (synchronous, active low) clears all slots, the selected slot and the
// configuration registers; there is no clearing pass.
// The config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes at once and is
// to be used only while the block is idle.
module multitouch_slot_tracker_unit
    import mtst_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [TYPE_W-1:0]           i_ev_type,
    input  logic [CODE_W-1:0]           i_ev_code,
    input  logic signed [COORD_W-1:0]   i_ev_value,
    input  logic [OFF_W-1:0]            i_disp_offset_x,
    input  logic [OFF_W-1:0]            i_disp_offset_y,
    input  logic [SIZE_W-1:0]           i_disp_width,
    input  logic [SIZE_W-1:0]           i_disp_height,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [SLOT_ID_W-1:0]        o_slot_id,
    output logic signed [COORD_W-1:0]   o_touch_x,
    output logic signed [COORD_W-1:0]   o_touch_y,
    output logic                        o_none_active,
    output logic                        o_last
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    t_state r_state, n_state;

    // configuration
    logic                       r_cal_en;
    logic signed [COORD_W-1:0]  r_raw_min_x, r_raw_max_x, r_raw_min_y, r_raw_max_y;

    // slot table
    logic [SLOT_W-1:0]          r_sel_slot;
    logic [MAX_SLOTS-1:0]       r_active;
    logic signed [COORD_W-1:0]  r_raw_x [MAX_SLOTS];
    logic signed [COORD_W-1:0]  r_raw_y [MAX_SLOTS];

    // report context
    logic [OFF_W-1:0]           r_off_x, r_off_y;
    logic [SIZE_W-1:0]          r_size_x, r_size_y;
    logic [SLOT_W-1:0]          r_idx, r_slot;
    logic                       r_none, r_axis;
    logic signed [COORD_W-1:0]  r_res_x, r_res_y;

    // bit-serial multiply / divide unit
    logic [PROD_W-1:0]          r_mcand, r_prod;
    logic [SPAN_MAG_W-1:0]      r_mplier;
    logic [DIFF_W-1:0]          r_den, r_rem;
    logic                       r_neg;
    logic [OFF_W-1:0]           r_lo;
    logic signed [HI_W-1:0]     r_hi;
    logic [CNT_W-1:0]           r_cnt;

    // output register
    logic                       r_out_valid;
    logic [SLOT_ID_W-1:0]       r_out_slot;
    logic signed [COORD_W-1:0]  r_out_x, r_out_y;
    logic                       r_out_none, r_out_last;

    logic in_fire, out_free, emit_fire;
    logic scan_found, emit_more, emit_last;
    logic [SLOT_W-1:0] scan_slot;

    logic signed [COORD_W-1:0]  ax_raw, ax_min, ax_max;
    logic [OFF_W-1:0]           ax_off;
    logic [SIZE_W-1:0]          ax_size;
    logic signed [DIFF_W-1:0]   p_diff, p_den;
    logic signed [SIZE_W:0]     p_span;
    logic [DIFF_W-1:0]          p_diff_mag, p_den_mag;
    logic [SPAN_MAG_W-1:0]      p_span_mag;
    logic signed [HI_W-1:0]     p_hi;

    logic [DIFF_W:0]            d_sh, d_sub;
    logic                       d_ge;

    logic signed [VAL_W-1:0]    f_q, f_lo, f_hi, f_val;

    // Handshake and sequencer strobes
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        out_free   = !r_out_valid || i_out_ready;
        emit_fire  = (r_state == S_EMIT) && out_free;
        in_fire    = i_in_valid && o_in_ready;
    end

    // First active slot at or above the scan index
    always_comb begin
        scan_found = 1'b0;
        scan_slot  = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (!scan_found && r_active[i] && (SLOT_W'(i) >= r_idx)) begin
                scan_found = 1'b1;
                scan_slot  = SLOT_W'(i);
            end
        end
    end

    // Any active slot beyond the one being emitted
    always_comb begin
        emit_more = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (r_active[i] && (SLOT_W'(i) > r_slot)) begin
                emit_more = 1'b1;
            end
        end
        emit_last = r_none || !emit_more;
    end

    // Axis operands: sign-magnitude split for the serial unit
    always_comb begin
        ax_raw  = r_axis ? r_raw_y[r_slot] : r_raw_x[r_slot];
        ax_min  = r_axis ? r_raw_min_y : r_raw_min_x;
        ax_max  = r_axis ? r_raw_max_y : r_raw_max_x;
        ax_off  = r_axis ? r_off_y : r_off_x;
        ax_size = r_axis ? r_size_y : r_size_x;

        p_diff = {ax_raw[COORD_W-1], ax_raw} - {ax_min[COORD_W-1], ax_min};
        p_den  = {ax_max[COORD_W-1], ax_max} - {ax_min[COORD_W-1], ax_min};
        p_span = $signed({1'b0, ax_size}) - $signed((SIZE_W+1)'(1));

        p_diff_mag = p_diff[DIFF_W-1] ? DIFF_W'(-p_diff) : DIFF_W'(p_diff);
        p_den_mag  = p_den[DIFF_W-1] ? DIFF_W'(-p_den) : DIFF_W'(p_den);
        p_span_mag = p_span[SIZE_W] ? SIZE_W'(-p_span) : p_span[SIZE_W-1:0];

        p_hi = $signed({3'b000, ax_off}) + $signed({2'b00, ax_size})
             - $signed(HI_W'(1));
    end

    // Restoring divide step
    always_comb begin
        d_sh  = {r_rem, r_prod[PROD_W-1]};
        d_ge  = (d_sh >= {1'b0, r_den});
        d_sub = d_sh - {1'b0, r_den};
    end

    // Sign, offset and clamp to the window
    always_comb begin
        f_q  = r_neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
        f_lo = $signed({{(VAL_W-OFF_W){1'b0}}, r_lo});
        f_hi = $signed({{(VAL_W-HI_W){r_hi[HI_W-1]}}, r_hi});
        f_val = f_q + f_lo;
        if (f_val > f_hi) f_val = f_hi;
        if (f_val < f_lo) f_val = f_lo;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_fire && i_req_type) n_state = S_SCAN;
            S_SCAN: n_state = (scan_found && r_cal_en) ? S_PREP : S_EMIT;
            S_PREP: n_state = (p_den == '0) ? S_FIX : S_MUL;
            S_MUL:  if (r_cnt == CNT_W'(SPAN_MAG_W - 1)) n_state = S_DIV;
            S_DIV:  if (r_cnt == CNT_W'(PROD_W - 1)) n_state = S_FIX;
            S_FIX:  n_state = r_axis ? S_EMIT : S_PREP;
            S_EMIT: if (out_free) n_state = emit_last ? S_IDLE : S_SCAN;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cal_en    <= 1'b0;
            r_raw_min_x <= '0;
            r_raw_max_x <= '0;
            r_raw_min_y <= '0;
            r_raw_max_y <= '0;
            r_sel_slot  <= '0;
            r_active    <= '0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_raw_x[i] <= '0;
                r_raw_y[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // register writes
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_CAL_ENABLE: r_cal_en    <= i_cfg_data[0];
                    REG_RAW_MIN_X:  r_raw_min_x <= $signed(i_cfg_data[COORD_W-1:0]);
                    REG_RAW_MAX_X:  r_raw_max_x <= $signed(i_cfg_data[COORD_W-1:0]);
                    REG_RAW_MIN_Y:  r_raw_min_y <= $signed(i_cfg_data[COORD_W-1:0]);
                    REG_RAW_MAX_Y:  r_raw_max_y <= $signed(i_cfg_data[COORD_W-1:0]);
                    default: ;
                endcase
            end

            // event decode
            if (in_fire && !i_req_type) begin
                if (i_ev_type == EVT_ABS) begin
                    case (i_ev_code)
                        CODE_SLOT: begin
                            if (i_ev_value < 0) begin
                                r_sel_slot <= '0;
                            end else if (i_ev_value > 32'(MAX_SLOTS - 1)) begin
                                r_sel_slot <= SLOT_W'(MAX_SLOTS - 1);
                            end else begin
                                r_sel_slot <= i_ev_value[SLOT_W-1:0];
                            end
                        end
                        CODE_TRACK: r_active[r_sel_slot] <= !i_ev_value[COORD_W-1];
                        CODE_MT_X:  r_raw_x[r_sel_slot]  <= i_ev_value;
                        CODE_MT_Y:  r_raw_y[r_sel_slot]  <= i_ev_value;
                        CODE_X:     r_raw_x[0]           <= i_ev_value;
                        CODE_Y:     r_raw_y[0]           <= i_ev_value;
                        default: ;
                    endcase
                end else if (i_ev_type == EVT_KEY && i_ev_code == CODE_TOUCH) begin
                    r_active[0] <= (i_ev_value != 0);
                end
            end
        end
    end

    // Report datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_req_type) begin
                    r_off_x  <= i_disp_offset_x;
                    r_off_y  <= i_disp_offset_y;
                    r_size_x <= i_disp_width;
                    r_size_y <= i_disp_height;
                    r_idx    <= '0;
                end
            end
            S_SCAN: begin
                r_slot  <= scan_found ? scan_slot : '0;
                r_none  <= !scan_found;
                r_axis  <= 1'b0;
                r_res_x <= scan_found ? r_raw_x[scan_slot] : '0;
                r_res_y <= scan_found ? r_raw_y[scan_slot] : '0;
            end
            S_PREP: begin
                r_mcand  <= PROD_W'(p_diff_mag);
                r_mplier <= p_span_mag;
                r_prod   <= '0;
                r_rem    <= '0;
                r_den    <= p_den_mag;
                r_neg    <= p_diff[DIFF_W-1] ^ p_span[SIZE_W] ^ p_den[DIFF_W-1];
                r_lo     <= ax_off;
                r_hi     <= p_hi;
                r_cnt    <= '0;
            end
            S_MUL: begin
                // shift-add, one multiplier bit per cycle
                if (r_mplier[0]) r_prod <= r_prod + r_mcand;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= (r_cnt == CNT_W'(SPAN_MAG_W - 1)) ? '0 : r_cnt + 1'b1;
            end
            S_DIV: begin
                // quotient bits shift in where dividend bits leave
                r_rem  <= d_ge ? d_sub[DIFF_W-1:0] : d_sh[DIFF_W-1:0];
                r_prod <= {r_prod[PROD_W-2:0], d_ge};
                r_cnt  <= r_cnt + 1'b1;
            end
            S_FIX: begin
                if (r_axis) r_res_y <= f_val[COORD_W-1:0];
                else        r_res_x <= f_val[COORD_W-1:0];
                r_axis <= 1'b1;
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out_slot <= SLOT_ID_W'(r_slot);
                    r_out_x    <= r_res_x;
                    r_out_y    <= r_res_y;
                    r_out_none <= r_none;
                    r_out_last <= emit_last;
                    r_idx      <= SLOT_W'(r_slot + 1'b1);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_id     = r_out_slot;
    assign o_touch_x     = r_out_x;
    assign o_touch_y     = r_out_y;
    assign o_none_active = r_out_none;
    assign o_last        = r_out_last;

    // Checks
    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_sel_slot} < (SLOT_W+1)'(MAX_SLOTS))
        else $error("selected slot out of range");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_den)
        else $error("divider remainder not below divisor");

    a_emit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && !r_none |-> r_active[r_slot])
        else $error("emitting an inactive slot");

    a_last_ends_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire && emit_last |=> r_state == S_IDLE && o_out_valid && o_last)
        else $error("final result did not end the report");

    a_none_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_active |->
            o_last && o_slot_id == '0 && o_touch_x == '0 && o_touch_y == '0)
        else $error("none_active result malformed");

endmodule
